// ----- design/mfde_pkg.sv -----
`timescale 1ns / 1ps

package mfde_pkg;

    // Command codes carried on the opcode field.
    localparam logic [2:0] OP_PLOT   = 3'd0;
    localparam logic [2:0] OP_FILL   = 3'd1;
    localparam logic [2:0] OP_CHAR   = 3'd2;
    localparam logic [2:0] OP_SCROLL = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Pixel operations carried on the color field.
    localparam logic [1:0] COLOR_SET   = 2'd0;
    localparam logic [1:0] COLOR_CLEAR = 2'd1;
    localparam logic [1:0] COLOR_INV   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PIX_RD,
        ST_PIX_WAIT,
        ST_PIX_WR,
        ST_MOV_RD,
        ST_MOV_WAIT,
        ST_MOV_WR,
        ST_READ_WAIT,
        ST_READ_CAP,
        ST_OUT
    } state_t;

    // Fixed 4x4 font, two glyphs per byte.
    function automatic logic [7:0] font_byte(input logic [6:0] addr);
        logic [7:0] rom [0:127];
        rom = '{
            8'h04, 8'haa, 8'h79, 8'h74, 8'h24, 8'ha0, 8'h00, 8'h01,
            8'h04, 8'haf, 8'hc2, 8'ha4, 8'h42, 8'h44, 8'h00, 8'h02,
            8'h00, 8'h0a, 8'h74, 8'he0, 8'h42, 8'hae, 8'h2e, 8'h04,
            8'h04, 8'h0f, 8'he9, 8'h50, 8'h24, 8'h04, 8'h40, 8'h48,
            8'h62, 8'h6e, 8'h9f, 8'h7f, 8'h66, 8'h44, 8'h00, 8'h06,
            8'hb6, 8'h93, 8'h98, 8'hc1, 8'hfd, 8'h00, 8'h2e, 8'h4b,
            8'hd2, 8'h21, 8'h77, 8'hb2, 8'h93, 8'h02, 8'h40, 8'h20,
            8'h62, 8'hfe, 8'h1e, 8'h62, 8'h6e, 8'h44, 8'h2e, 8'h42,
            8'h66, 8'he6, 8'hef, 8'hf6, 8'h97, 8'hfb, 8'h8d, 8'h96,
            8'ha9, 8'hb9, 8'h98, 8'h88, 8'h92, 8'h1c, 8'h8f, 8'hd9,
            8'hdf, 8'hd8, 8'h9e, 8'heb, 8'hf2, 8'h9a, 8'h89, 8'hb9,
            8'h69, 8'he6, 8'hef, 8'h86, 8'h97, 8'h69, 8'hf9, 8'h96,
            8'he6, 8'he7, 8'h79, 8'h99, 8'h95, 8'hf6, 8'h86, 8'h40,
            8'h99, 8'h98, 8'h29, 8'h99, 8'h65, 8'h24, 8'h42, 8'ha0,
            8'hea, 8'he7, 8'h29, 8'haf, 8'h62, 8'h44, 8'h22, 8'h00,
            8'h85, 8'h9e, 8'h26, 8'h4d, 8'h92, 8'hf6, 8'h16, 8'h0f
        };
        return rom[addr];
    endfunction

endpackage

// ----- design/mfde_frame_ram.sv -----
`timescale 1ns / 1ps

module mfde_frame_ram #(
    parameter int AW = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [0:(1<<AW)-1];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/mono_framebuffer_draw_engine_unit.sv -----
`timescale 1ns / 1ps

// Drawing engine for a 1-bit framebuffer of FRAME_ROWS rows of four 32-bit
// words, most significant bit leftmost, drawn through a clipped window.
// Input channel: in_valid/in_stall with the command fields; output channel:
// out_valid/out_stall with read_data and done_res, one result per command.
// Every pixel is handled by one shared read-modify-write sequence on the
// frame memory (one write port, one registered read port): a drawn pixel
// passes the read, wait and write states, a clipped or blank one skips the
// wait, and the result is posted at the end. A plot is one pixel, a glyph
// 16 pixels, a rectangle w*h (one clipped pass when it is empty). A scroll
// moves each word through the read, wait and write states, passes over a
// row outside the frame without a write, and then fills the freed rows
// pixel by pixel. A word read passes a wait and a capture state. Commands
// are taken one at a time; in_stall is high while a command is in work or
// its result is still waiting. After reset the engine clears the frame
// memory, all FRAME_ROWS*4 words, one word per cycle, with in_stall held
// high. A result waits in its output register while out_stall is high.
module mono_framebuffer_draw_engine_unit #(
    parameter int FRAME_ROWS    = 64,
    parameter int WINDOW_WIDTH  = 126,
    parameter int WINDOW_HEIGHT = 55,
    parameter int TOP_MARGIN    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic signed [7:0] x_pos,
    input  logic signed [6:0] y_pos,
    input  logic [6:0]  width,
    input  logic [5:0]  height,
    input  logic [1:0]  color,
    input  logic [7:0]  char_code,
    input  logic [7:0]  word_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        done_res
);

    localparam int RW = $clog2(FRAME_ROWS);
    localparam int AW = RW + 2;
    localparam int WORDS = FRAME_ROWS * 4;

    mfde_pkg::state_t state_reg, state_next;

    // Command registers.
    logic [2:0]  op_reg;
    logic signed [9:0] x0_reg;
    logic signed [8:0] y0_reg;
    logic [6:0]  w_reg;
    logic [6:0]  h_reg;
    logic [1:0]  col_reg;
    logic [5:0]  g_reg;
    // Walk counters: column and row offsets within the current shape.
    logic [6:0]  j_reg, j_next;
    logic [6:0]  i_reg, i_next;
    logic [1:0]  wsub_reg, wsub_next;
    logic [AW:0] clr_reg, clr_next;
    logic [31:0] res_reg;
    logic        ov_reg;

    // Memory port signals.
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data, rd_data;

    mfde_frame_ram #(.AW(AW)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // Current pixel location and its clip test.
    logic signed [9:0] px;
    logic signed [9:0] py;
    logic [9:0] fcol;
    logic [9:0] frow;
    logic       pix_ok;
    logic       glyph_bit;
    logic [7:0] gbyte;
    logic [6:0] gaddr;
    logic [AW-1:0] pix_addr;
    logic [31:0] pix_mask;
    logic       last_j, last_i;
    // Scroll move rows.
    logic [9:0] mv_dst, mv_src;
    logic       mv_ok;
    logic [6:0] mv_count;

    always_comb
    begin
        px = x0_reg + $signed({3'b000, j_reg});
        py = $signed({y0_reg[8], y0_reg}) + $signed({3'b000, i_reg});
        fcol = 10'(px + 10'sd1);
        frow = 10'(py + 10'(TOP_MARGIN));
        gaddr = {g_reg[5:4], i_reg[1:0], g_reg[3:1]};
        gbyte = mfde_pkg::font_byte(gaddr);
        glyph_bit = gbyte[3'(7 - {g_reg[0], j_reg[1:0]})];
        pix_ok = (px >= 0) && (px < 10'(WINDOW_WIDTH)) && (py >= 0)
            && (py < 10'(WINDOW_HEIGHT)) && (frow < 10'(FRAME_ROWS))
            && (fcol < 10'd128)
            && ((op_reg != mfde_pkg::OP_CHAR) || glyph_bit)
            && (w_reg != 7'd0) && (h_reg != 7'd0);
        pix_addr = {frow[RW-1:0], fcol[6:5]};
        pix_mask = 32'h8000_0000 >> fcol[4:0];
        last_j = (j_reg + 7'd1 >= w_reg) || (w_reg == 7'd0);
        last_i = (i_reg + 7'd1 >= h_reg) || (h_reg == 7'd0);
        mv_count = 7'(WINDOW_HEIGHT) - h_reg;
        mv_dst = 10'(TOP_MARGIN) + {3'b000, i_reg};
        mv_src = mv_dst + {3'b000, h_reg};
        mv_ok = (mv_dst < 10'(FRAME_ROWS)) && (mv_src < 10'(FRAME_ROWS));
    end

    // Sequencer: next state, memory port and counters.
    always_comb
    begin
        state_next = state_reg;
        j_next = j_reg;
        i_next = i_reg;
        wsub_next = wsub_reg;
        clr_next = clr_reg;
        wr_en = 1'b0;
        wr_addr = pix_addr;
        wr_data = rd_data;
        rd_addr = pix_addr;
        case (state_reg)
            mfde_pkg::ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                wr_data = '0;
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(WORDS - 1))
                begin
                    state_next = mfde_pkg::ST_IDLE;
                end
            end
            mfde_pkg::ST_IDLE:
            begin
                j_next = '0;
                i_next = '0;
                wsub_next = '0;
            end
            mfde_pkg::ST_PIX_RD:
            begin
                if (pix_ok)
                begin
                    state_next = mfde_pkg::ST_PIX_WAIT;
                end
                else
                begin
                    state_next = mfde_pkg::ST_PIX_WR;
                end
            end
            mfde_pkg::ST_PIX_WAIT:
            begin
                state_next = mfde_pkg::ST_PIX_WR;
            end
            mfde_pkg::ST_PIX_WR:
            begin
                if (pix_ok)
                begin
                    wr_en = 1'b1;
                    case (col_reg)
                        mfde_pkg::COLOR_SET:   wr_data = rd_data | pix_mask;
                        mfde_pkg::COLOR_CLEAR: wr_data = rd_data & ~pix_mask;
                        mfde_pkg::COLOR_INV:   wr_data = rd_data ^ pix_mask;
                        default:               wr_data = rd_data;
                    endcase
                end
                state_next = mfde_pkg::ST_PIX_RD;
                if (last_j)
                begin
                    j_next = '0;
                    if (last_i)
                    begin
                        state_next = mfde_pkg::ST_OUT;
                    end
                    else
                    begin
                        i_next = i_reg + 7'd1;
                    end
                end
                else
                begin
                    j_next = j_reg + 7'd1;
                end
            end
            mfde_pkg::ST_MOV_RD:
            begin
                rd_addr = {mv_src[RW-1:0], wsub_reg};
                if (i_reg >= mv_count)
                begin
                    // Moves finished; fill the freed rows.
                    i_next = '0;
                    state_next = mfde_pkg::ST_PIX_RD;
                end
                else if (mv_ok)
                begin
                    state_next = mfde_pkg::ST_MOV_WAIT;
                end
                else
                begin
                    state_next = mfde_pkg::ST_MOV_WR;
                end
            end
            mfde_pkg::ST_MOV_WAIT:
            begin
                // Hold the source address so the read data stays on the moved word.
                rd_addr = {mv_src[RW-1:0], wsub_reg};
                state_next = mfde_pkg::ST_MOV_WR;
            end
            mfde_pkg::ST_MOV_WR:
            begin
                wr_en = mv_ok;
                wr_addr = {mv_dst[RW-1:0], wsub_reg};
                wr_data = rd_data;
                wsub_next = wsub_reg + 2'd1;
                if (wsub_reg == 2'd3 || !mv_ok)
                begin
                    wsub_next = '0;
                    i_next = i_reg + 7'd1;
                end
                state_next = mfde_pkg::ST_MOV_RD;
            end
            mfde_pkg::ST_READ_WAIT:
            begin
                state_next = mfde_pkg::ST_READ_CAP;
            end
            mfde_pkg::ST_READ_CAP:
            begin
                state_next = mfde_pkg::ST_OUT;
            end
            mfde_pkg::ST_OUT:
            begin
                if (!ov_reg)
                begin
                    state_next = mfde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfde_pkg::ST_IDLE;
            end
        endcase
        if (state_reg == mfde_pkg::ST_READ_WAIT || state_reg == mfde_pkg::ST_IDLE)
        begin
            rd_addr = AW'(word_index);
            if (state_reg == mfde_pkg::ST_READ_WAIT)
            begin
                rd_addr = res_reg[AW-1:0];
            end
        end
        if (state_reg == mfde_pkg::ST_IDLE && in_valid && !ov_reg)
        begin
            case (opcode)
                mfde_pkg::OP_PLOT, mfde_pkg::OP_FILL, mfde_pkg::OP_CHAR:
                    state_next = mfde_pkg::ST_PIX_RD;
                mfde_pkg::OP_SCROLL:
                    state_next = mfde_pkg::ST_MOV_RD;
                mfde_pkg::OP_READ:
                    state_next = mfde_pkg::ST_READ_WAIT;
                default:
                    state_next = mfde_pkg::ST_OUT;
            endcase
        end
    end

    assign in_stall = (state_reg != mfde_pkg::ST_IDLE) || ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfde_pkg::ST_CLEAR;
            clr_reg <= '0;
            ov_reg <= 1'b0;
            j_reg <= '0;
            i_reg <= '0;
            wsub_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            j_reg <= j_next;
            i_reg <= i_next;
            wsub_reg <= wsub_next;
            if (state_reg == mfde_pkg::ST_OUT && !ov_reg)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Command capture and result register.
    always_ff @(posedge clk)
    begin
        if (state_reg == mfde_pkg::ST_IDLE && in_valid && !ov_reg)
        begin
            op_reg <= opcode;
            col_reg <= color;
            g_reg <= 6'(char_code - 8'd32 - ((char_code - 8'd32) >= 8'd64 ? 8'd32 : 8'd0));
            res_reg <= '0;
            case (opcode)
                mfde_pkg::OP_PLOT:
                begin
                    x0_reg <= 10'(x_pos);
                    y0_reg <= 9'(y_pos);
                    w_reg <= 7'd1;
                    h_reg <= 7'd1;
                end
                mfde_pkg::OP_CHAR:
                begin
                    x0_reg <= 10'(x_pos);
                    y0_reg <= 9'(y_pos);
                    w_reg <= 7'd4;
                    h_reg <= 7'd4;
                end
                mfde_pkg::OP_SCROLL:
                begin
                    // Fill rectangle below the moved rows.
                    x0_reg <= '0;
                    w_reg <= 7'(WINDOW_WIDTH);
                    if (height > 6'(WINDOW_HEIGHT))
                    begin
                        h_reg <= 7'(WINDOW_HEIGHT);
                        y0_reg <= '0;
                    end
                    else
                    begin
                        h_reg <= {1'b0, height};
                        y0_reg <= 9'(WINDOW_HEIGHT) - 9'(height);
                    end
                end
                mfde_pkg::OP_READ:
                begin
                    res_reg <= {24'd0, word_index};
                end
                default:
                begin
                    x0_reg <= 10'(x_pos);
                    y0_reg <= 9'(y_pos);
                    w_reg <= width;
                    h_reg <= {1'b0, height};
                end
            endcase
        end
        else if (state_reg == mfde_pkg::ST_READ_CAP)
        begin
            res_reg <= ({24'd0, res_reg[7:0]} < 32'(WORDS)) ? rd_data : '0;
        end
        else if (state_reg == mfde_pkg::ST_OUT && op_reg != mfde_pkg::OP_READ && !ov_reg)
        begin
            res_reg <= '0;
        end
    end

    assign out_valid = ov_reg;
    assign read_data = res_reg;
    assign done_res = 1'b1;

endmodule
